/* sv/f2fx_pkg.sv */
`default_nettype none

package f2fx_pkg;

  localparam int unsigned FLOAT_W = 32;
  localparam int unsigned EXP_W   = 8;
  localparam int unsigned FRAC_W  = 23;
  localparam int unsigned MANT_W  = FRAC_W + 1;
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned VAL_W   = MAG_W + 1;
  localparam int unsigned FIX_W   = 12;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned SHAMT_W = 5;
  localparam int unsigned SHIFT_W = 10;

  localparam logic [SHIFT_W-1:0] EXP_BIAS_M1 = SHIFT_W'(126);
  localparam logic [MAG_W-1:0]   MAG_MAX     = {MAG_W{1'b1}};
  localparam logic [VAL_W-1:0]   VAL_NEG_SAT = {1'b1, {MAG_W{1'b0}}};

  typedef struct packed {
    logic [FLOAT_W-1:0] float_bits;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] fixed_value;
    logic                    last_out;
  } out_word_t;

endpackage

`default_nettype wire

/* sv/float_to_fixed12_convert.sv */
// float_to_fixed12_convert
// converts one single-precision float word per cycle into a signed 12-bit
// fixed-point word, scaled by the point position held in the config register
// input: drive in_data and pulse start; a word is taken on every edge with
// start high and busy low, and busy is never raised, so one word per cycle
// config: cfg_we with cfg_wdata writes the point position; write it only
// while no word is in flight
// output: out_valid marks out_data for exactly one cycle; the receiver cannot
// stall, and the pipeline has no stall path
// pipeline: an accepted word passes through three register stages (exponent/shift
// decode, barrel shift with rounding, sign and scale) before out_valid is
// high; throughput one word per cycle
// reset: synchronous active-low rst_n clears the stage valid bits and sets
// the point position to zero; words in flight are dropped
`default_nettype none

module float_to_fixed12_convert
  import f2fx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  output out_word_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [POS_W-1:0] cfg_wdata
);

  logic [POS_W-1:0] point_pos_r;

  // stage 1
  logic               valid1_r;
  logic               zero1_r;
  logic               sat1_r;
  logic               sign1_r;
  logic               last1_r;
  logic [SHAMT_W-1:0] shamt1_r;
  logic [MANT_W-1:0]  mant1_r;

  logic               zero1_nxt;
  logic               sat1_nxt;
  logic [SHIFT_W-1:0] shift_s1;
  logic [EXP_W-1:0]   expo_s1;
  logic               accept;

  // stage 2
  logic             valid2_r;
  logic             sat2_r;
  logic             sign2_r;
  logic             last2_r;
  logic [MAG_W-1:0] mag2_r;

  logic [MANT_W-1:0] shifted_s2;
  logic [MAG_W-1:0]  mag_raw_s2;
  logic              rnd_s2;
  logic [MAG_W-1:0]  mag2_nxt;
  logic              sat2_nxt;

  // stage 3
  logic             out_valid_r;
  out_word_t        out_data_r;
  logic [VAL_W-1:0] val_s3;
  out_word_t        out_data_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_pos_r <= '0;
    end else if (cfg_we) begin
      point_pos_r <= cfg_wdata;
    end
  end

  // exponent decode and shift amount
  always_comb begin
    expo_s1   = in_data.float_bits[FLOAT_W-2 -: EXP_W];
    shift_s1  = SHIFT_W'(point_pos_r) + EXP_BIAS_M1 - SHIFT_W'(expo_s1);
    sat1_nxt  = shift_s1[SHIFT_W-1];
    zero1_nxt = (in_data.float_bits == '0)
              | (~shift_s1[SHIFT_W-1] & (shift_s1[SHIFT_W-2:SHAMT_W] != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else begin
      valid1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      zero1_r  <= zero1_nxt;
      sat1_r   <= sat1_nxt;
      sign1_r  <= in_data.float_bits[FLOAT_W-1];
      last1_r  <= in_data.last_in;
      shamt1_r <= shift_s1[SHAMT_W-1:0];
      mant1_r  <= {1'b1, in_data.float_bits[FRAC_W-1:0]};
    end
  end

  // alignment and rounding
  always_comb begin
    shifted_s2 = mant1_r >> shamt1_r;
    mag_raw_s2 = shifted_s2[MANT_W-1 -: MAG_W];
    rnd_s2     = shifted_s2[MANT_W-MAG_W-1];
    mag2_nxt   = mag_raw_s2;
    sat2_nxt   = 1'b0;
    if (sat1_r) begin
      mag2_nxt = MAG_MAX;
      sat2_nxt = 1'b1;
    end else if (zero1_r) begin
      mag2_nxt = '0;
    end else if (rnd_s2) begin
      if (mag_raw_s2 == MAG_MAX) begin
        sat2_nxt = 1'b1;
      end else begin
        mag2_nxt = mag_raw_s2 + MAG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
    end else begin
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid1_r) begin
      mag2_r  <= mag2_nxt;
      sat2_r  <= sat2_nxt;
      sign2_r <= sign1_r;
      last2_r <= last1_r;
    end
  end

  // sign and scale down by sixteen, rounding toward minus infinity
  always_comb begin
    if (sign2_r) begin
      if (sat2_r && (mag2_r != '0)) begin
        val_s3 = VAL_NEG_SAT;
      end else begin
        val_s3 = VAL_W'(0) - {1'b0, mag2_r};
      end
    end else begin
      val_s3 = {1'b0, mag2_r};
    end
    out_data_nxt.fixed_value = val_s3[VAL_W-1 -: FIX_W];
    out_data_nxt.last_out    = last2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid2_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
